FILE: rtl/core/ufr_pkg.sv
// Package for the union-find-with-rollback unit: sizes, request and status codes.
// No dependencies.
`default_nettype none
package ufr_pkg;
    localparam int NODES_DEFAULT   = 1024;
    localparam int HISTORY_DEFAULT = 1024;
    localparam int NODE_W          = 10;

    typedef enum logic [1:0] {
        KIND_UNION    = 2'd0,
        KIND_ROLLBACK = 2'd1,
        KIND_FIND     = 2'd2,
        KIND_SPARE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_JOINED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;
endpackage
`default_nettype wire

FILE: rtl/core/ufr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // registered read; a write cycle returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/union_find_with_rollback_unit.sv
// Top level of the union-find-with-rollback unit; uses ufr_pkg and ufr_ram.
// Find walks from a to its root; union walks from a and b, logs history, merges unless
// joined, then walks from a again (no log or merge when history is full); rollback restores
// the last entry unless history is empty. The next beat is accepted after the strobe.
// After reset a clearing pass initializes the node table; busy is high then.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
`default_nettype none
module union_find_with_rollback_unit #(
    parameter int NODES         = ufr_pkg::NODES_DEFAULT,
    parameter int HISTORY_DEPTH = ufr_pkg::HISTORY_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] kind,
    input  wire logic [9:0] node_a,
    input  wire logic [9:0] node_b,
    output logic            done,
    output logic [9:0]      root,
    output logic [9:0]      set_minimum,
    output logic [1:0]      status
);
    localparam int AW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SW   = $clog2(NODES + 1);
    localparam int NW   = AW + SW + AW;        // parent, size, minimum
    localparam int EW   = 4 * AW + 2 * SW;     // history entry

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_WAIT, S_WALK_CHK,
        S_U_HIST, S_U_RDA, S_U_WAITA, S_U_RDB, S_U_WAITB, S_U_GOTB, S_U_WRS, S_U_WRB,
        S_RB_RD, S_RB_WAIT, S_RB_WRB, S_RB_WRA, S_FIN_RD, S_FIN_WAIT, S_OUT
    } state_t;

    typedef enum logic [1:0] { W_A, W_B, W_FINAL } walk_t;

    state_t            state_reg;
    walk_t             walk_reg;
    logic [AW-1:0]     a_reg, b_reg, cur_reg, ra_reg, rb_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     clr_reg;
    logic [1:0]        status_reg;
    logic [AW-1:0]     root_out_reg, min_out_reg;
    logic              done_reg;
    logic [NW-1:0]     na_reg;                 // node record of root a
    logic [EW-1:0]     entry_reg;

    // node table port
    logic              n_we;
    logic [AW-1:0]     n_addr;
    logic [NW-1:0]     n_wdata, n_rdata;
    // history port
    logic              h_we;
    logic [HW-1:0]     h_addr;
    logic [EW-1:0]     h_wdata, h_rdata;

    ufr_ram #(.WIDTH(NW), .DEPTH(NODES)) u_nodes (
        .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
    );
    ufr_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
    );

    // reduce a node index into the table by binary compare and subtract
    function automatic logic [AW-1:0] idx(input logic [9:0] v);
        logic [31:0] w;
        w = 32'(v);
        for (int k = 9; k >= 0; k--)
        begin
            if (w >= (32'(NODES) << k))
            begin
                w = w - (32'(NODES) << k);
            end
        end
        return w[AW-1:0];
    endfunction

    function automatic logic [NW-1:0] rec(input logic [AW-1:0] p, input logic [SW-1:0] s,
                                          input logic [AW-1:0] m);
        return {p, s, m};
    endfunction

    // field views of the read record
    logic [AW-1:0] rd_par, rd_min, na_min;
    logic [SW-1:0] rd_size, na_size;
    assign rd_par  = n_rdata[NW-1 -: AW];
    assign rd_size = n_rdata[AW +: SW];
    assign rd_min  = n_rdata[AW-1:0];
    assign na_size = na_reg[AW +: SW];
    assign na_min  = na_reg[AW-1:0];

    // entry layout {ra, rb, sa, sb, ma, mb}
    logic [AW-1:0] e_ra, e_rb, e_ma, e_mb;
    logic [SW-1:0] e_sa, e_sb;
    assign e_ra = entry_reg[EW-1 -: AW];
    assign e_rb = entry_reg[EW-AW-1 -: AW];
    assign e_sa = entry_reg[2*AW+SW +: SW];
    assign e_sb = entry_reg[2*AW +: SW];
    assign e_ma = entry_reg[AW +: AW];
    assign e_mb = entry_reg[AW-1:0];

    // union decision: a goes under b unless size a > size b
    logic          a_big;
    logic [AW-1:0] small_r, big_r, new_min;
    logic [SW-1:0] big_size;
    logic [AW-1:0] big_min_in, small_min_in;
    assign a_big        = na_size > rd_size;
    assign small_r      = a_big ? rb_reg : ra_reg;
    assign big_r        = a_big ? ra_reg : rb_reg;
    assign big_size     = SW'(na_size + rd_size);
    assign big_min_in   = a_big ? na_min : rd_min;
    assign small_min_in = a_big ? rd_min : na_min;
    assign new_min      = (small_min_in < big_min_in) ? small_min_in : big_min_in;

    // memory port control
    always_comb
    begin
        n_we    = 1'b0;
        n_addr  = cur_reg;
        n_wdata = na_reg;
        h_we    = 1'b0;
        h_addr  = count_reg[HW-1:0];
        h_wdata = {ra_reg, rb_reg, na_size, rd_size, na_min, rd_min};
        unique case (state_reg)
            S_CLEAR:
            begin
                n_we    = 1'b1;
                n_addr  = clr_reg;
                n_wdata = rec(clr_reg, SW'(1), clr_reg);
            end
            S_U_RDA:  n_addr = ra_reg;
            S_U_RDB:  n_addr = rb_reg;
            S_U_GOTB: h_we   = 1'b1;
            S_U_WRS:
            begin
                n_we    = 1'b1;
                n_addr  = small_r;
                n_wdata = rec(big_r, a_big ? rd_size : na_size, small_min_in);
            end
            S_U_WRB:
            begin
                n_we    = 1'b1;
                n_addr  = entry_reg[EW-1 -: AW];
                n_wdata = entry_reg[NW-1:0];
            end
            S_RB_RD:  h_addr = HW'(count_reg - CW'(1));
            S_RB_WRB:
            begin
                n_we    = 1'b1;
                n_addr  = e_rb;
                n_wdata = rec(e_rb, e_sb, e_mb);
            end
            S_RB_WRA:
            begin
                n_we    = 1'b1;
                n_addr  = e_ra;
                n_wdata = rec(e_ra, e_sa, e_ma);
            end
            S_FIN_RD: n_addr = cur_reg;
            default:  ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == NODES - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        a_reg      <= idx(node_a);
                        b_reg      <= idx(node_b);
                        cur_reg    <= idx(node_a);
                        status_reg <= ufr_pkg::ST_OK;
                        if (kind == ufr_pkg::KIND_ROLLBACK)
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg   <= ufr_pkg::ST_EMPTY;
                                root_out_reg <= '0;
                                min_out_reg  <= '0;
                                state_reg    <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_RB_RD;
                            end
                        end
                        else
                        begin
                            walk_reg  <= (kind == ufr_pkg::KIND_UNION) ? W_A : W_FINAL;
                            state_reg <= S_WALK_RD;
                        end
                    end
                end
                S_WALK_RD:   state_reg <= S_WALK_WAIT;
                S_WALK_WAIT: state_reg <= S_WALK_CHK;
                S_WALK_CHK:
                begin
                    // follow parent until a self-parented node
                    if (rd_par != cur_reg)
                    begin
                        cur_reg   <= rd_par;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        priority case (walk_reg)
                            W_A:
                            begin
                                ra_reg    <= cur_reg;
                                cur_reg   <= b_reg;
                                walk_reg  <= W_B;
                                state_reg <= S_WALK_RD;
                            end
                            W_B:
                            begin
                                rb_reg <= cur_reg;
                                if (32'(count_reg) >= HISTORY_DEPTH)
                                begin
                                    status_reg <= ufr_pkg::ST_FULL;
                                    cur_reg    <= a_reg;
                                    walk_reg   <= W_FINAL;
                                    state_reg  <= S_WALK_RD;
                                end
                                else
                                begin
                                    state_reg <= S_U_RDA;
                                end
                            end
                            default:
                            begin
                                root_out_reg <= cur_reg;
                                min_out_reg  <= rd_min;
                                state_reg    <= S_OUT;
                            end
                        endcase
                    end
                end
                S_U_RDA:   state_reg <= S_U_WAITA;
                S_U_WAITA:
                begin
                    na_reg    <= n_rdata;
                    state_reg <= S_U_RDB;
                end
                S_U_RDB:   state_reg <= S_U_WAITB;
                S_U_WAITB: state_reg <= S_U_GOTB;
                S_U_GOTB:
                begin
                    // history entry is written this cycle; a copy is also kept in entry_reg
                    entry_reg <= {ra_reg, rb_reg, na_size, rd_size, na_min, rd_min};
                    if (ra_reg == rb_reg)
                    begin
                        status_reg <= ufr_pkg::ST_JOINED;
                        state_reg  <= S_U_HIST;
                    end
                    else
                    begin
                        state_reg <= S_U_WRS;
                    end
                end
                S_U_WRS:
                begin
                    // small root hung; stage big root record in entry scratch
                    entry_reg <= {big_r, {(EW-AW-NW){1'b0}}, rec(big_r, big_size, new_min)};
                    state_reg <= S_U_WRB;
                end
                S_U_WRB:   state_reg <= S_U_HIST;
                S_U_HIST:
                begin
                    count_reg <= count_reg + CW'(1);
                    cur_reg   <= a_reg;
                    walk_reg  <= W_FINAL;
                    state_reg <= S_WALK_RD;
                end
                S_RB_RD:   state_reg <= S_RB_WAIT;
                S_RB_WAIT:
                begin
                    entry_reg <= h_rdata;
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_RB_WRB;
                end
                S_RB_WRB:  state_reg <= S_RB_WRA;
                S_RB_WRA:
                begin
                    root_out_reg <= '0;
                    min_out_reg  <= '0;
                    state_reg    <= S_OUT;
                end
                S_FIN_RD:   state_reg <= S_FIN_WAIT;
                S_FIN_WAIT: state_reg <= S_OUT;
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE) || done_reg;
    assign done        = done_reg;
    assign root        = 10'(root_out_reg);
    assign set_minimum = 10'(min_out_reg);
    assign status      = status_reg;
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for union_find_with_rollback_unit: directed and random requests.
// Depends on ufr_pkg and the unit's RTL; predicts every result with its own disjoint-set table.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_NODES = 1024;
    localparam int N_HIST  = 1024;

    typedef struct {
        logic [9:0]       root;
        logic [9:0]       minimum;
        ufr_pkg::status_t status;
    } answer_t;

    typedef struct {
        logic [9:0]  ra, rb, ma, mb;
        logic [10:0] sa, sb;
    } undo_rec_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] kind;
    logic [9:0] node_a;
    logic [9:0] node_b;
    logic       done;
    logic [9:0] root;
    logic [9:0] set_minimum;
    logic [1:0] status;

    // Shadow disjoint-set table
    logic [9:0]  link_of[N_NODES];
    logic [10:0] members[N_NODES];
    logic [9:0]  least_of[N_NODES];
    undo_rec_t   history[N_HIST];
    int          history_len;

    answer_t pending_answers[$];
    int      errors;
    int      beats_sent;
    int      beats_checked;
    int      full_hits;
    int      empty_hits;
    int      joined_hits;

    union_find_with_rollback_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .node_a(node_a), .node_b(node_b),
        .done(done), .root(root), .set_minimum(set_minimum), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Walk to the root without compression
    function automatic logic [9:0] root_walk(logic [9:0] v);
        int steps;
        steps = 0;
        while (link_of[v] != v && steps < N_NODES)
        begin
            v = link_of[v];
            steps++;
        end
        return v;
    endfunction

    // Apply one accepted request to the shadow table and queue its answer
    task automatic predict_answer(logic [1:0] k, logic [9:0] a, logic [9:0] b);
        answer_t    ans;
        logic [9:0] ra, rb, lo, hi;
        undo_rec_t  rec;
        ans.root = '0;
        ans.minimum = '0;
        ans.status = ufr_pkg::ST_OK;
        if (k == ufr_pkg::KIND_UNION)
        begin
            ra = root_walk(a);
            rb = root_walk(b);
            if (history_len >= N_HIST)
            begin
                ans.status = ufr_pkg::ST_FULL;
            end
            else
            begin
                rec.ra = ra; rec.rb = rb;
                rec.sa = members[ra]; rec.sb = members[rb];
                rec.ma = least_of[ra]; rec.mb = least_of[rb];
                history[history_len] = rec;
                history_len++;
                if (ra == rb)
                begin
                    ans.status = ufr_pkg::ST_JOINED;
                end
                else
                begin
                    lo = ra;
                    hi = rb;
                    if (members[ra] > members[rb])
                    begin
                        lo = rb;
                        hi = ra;
                    end
                    members[hi] = members[hi] + members[lo];
                    link_of[lo] = hi;
                    if (least_of[lo] < least_of[hi])
                        least_of[hi] = least_of[lo];
                end
            end
            ans.root = root_walk(a);
            ans.minimum = least_of[ans.root];
        end
        else if (k == ufr_pkg::KIND_ROLLBACK)
        begin
            if (history_len == 0)
            begin
                ans.status = ufr_pkg::ST_EMPTY;
            end
            else
            begin
                history_len--;
                rec = history[history_len];
                members[rec.rb] = rec.sb;
                members[rec.ra] = rec.sa;
                link_of[rec.rb] = rec.rb;
                link_of[rec.ra] = rec.ra;
                least_of[rec.rb] = rec.mb;
                least_of[rec.ra] = rec.ma;
            end
        end
        else
        begin
            ans.root = root_walk(a);
            ans.minimum = least_of[ans.root];
        end
        pending_answers = {pending_answers, ans};
    endtask

    // Mostly short gaps, some long, many back to back
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one beat; returns right after the accepting edge with start still high
    task automatic send_request(logic [1:0] k, logic [9:0] a, logic [9:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        kind   <= k;
        node_a <= a;
        node_b <= b;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        predict_answer(k, a, b);
        beats_sent++;
    endtask

    // Check each result beat against the oldest answer
    always @(negedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            beats_checked++;
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no pending request: root=%0d min=%0d status=%0d",
                       root, set_minimum, status);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (root !== want.root)
                begin
                    $error("root: expected %0d, got %0d", want.root, root);
                    errors++;
                end
                if (set_minimum !== want.minimum)
                begin
                    $error("set_minimum: expected %0d, got %0d", want.minimum, set_minimum);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (want.status == ufr_pkg::ST_FULL) full_hits++;
                if (want.status == ufr_pkg::ST_EMPTY) empty_hits++;
                if (want.status == ufr_pkg::ST_JOINED) joined_hits++;
            end
        end
    end

    // Extremes, every request kind, empty history, joined union, spare kind
    task automatic test_directed();
        send_request(ufr_pkg::KIND_FIND, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_SPARE, 10'd1023, 10'd1023);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd1023, 10'd1023);
        send_request(ufr_pkg::KIND_UNION, 10'd0, 10'd1023);
        send_request(ufr_pkg::KIND_FIND, 10'd1023, 10'd0);
        send_request(ufr_pkg::KIND_UNION, 10'd1023, 10'd0);
        send_request(ufr_pkg::KIND_UNION, 10'd5, 10'd6);
        send_request(ufr_pkg::KIND_UNION, 10'd7, 10'd5);
        send_request(ufr_pkg::KIND_UNION, 10'd1023, 10'd7);
        send_request(ufr_pkg::KIND_FIND, 10'd6, 10'h2aa);
        send_request(ufr_pkg::KIND_SPARE, 10'd5, 10'h155);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_FIND, 10'd6, 10'd0);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
        send_request(ufr_pkg::KIND_FIND, 10'd1023, 10'd0);
    endtask

    // Fill the history, overflow it, then unwind part of it
    task automatic test_history_full();
        int i;
        for (i = 0; i < N_HIST + 3; i++)
            send_request(ufr_pkg::KIND_UNION, 10'($urandom_range(0, 63)),
                         10'($urandom_range(0, 63)));
        send_request(ufr_pkg::KIND_FIND, 10'd3, 10'd0);
        for (i = 0; i < 8; i++)
            send_request(ufr_pkg::KIND_ROLLBACK, 10'd0, 10'd0);
    endtask

    // Random mix: clustered unions build deep trees, finds probe, rollbacks unwind
    task automatic test_random(int count);
        int         i, r, span;
        logic [1:0] k;
        logic [9:0] a, b;
        for (i = 0; i < count; i++)
        begin
            span = ($urandom_range(0, 3) == 0) ? 1023 : 31;
            a = 10'($urandom_range(0, span));
            b = 10'($urandom_range(0, span));
            if ($urandom_range(0, 7) == 0)
                a = 10'($urandom_range(992, 1023));
            r = $urandom_range(0, 99);
            if (r < 45)
                k = ufr_pkg::KIND_UNION;
            else if (r < 65)
                k = ufr_pkg::KIND_ROLLBACK;
            else if (r < 92)
                k = ufr_pkg::KIND_FIND;
            else
                k = ufr_pkg::KIND_SPARE;
            send_request(k, a, b);
        end
    endtask

    initial
    begin
        int i;
        int waited;
        for (i = 0; i < N_NODES; i++)
        begin
            link_of[i] = 10'(i);
            members[i] = 11'd1;
            least_of[i] = 10'(i);
        end
        history_len = 0;
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        full_hits = 0;
        empty_hits = 0;
        joined_hits = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        kind   = ufr_pkg::KIND_FIND;
        node_a = '0;
        node_b = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_history_full();
        test_random(45);
        start <= 1'b0;

        // Drain outstanding results, then let the unit settle
        waited = 0;
        while (pending_answers.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d results never arrived", pending_answers.size());
            errors++;
        end

        $display("Sent %0d requests, checked %0d results (%0d joined, %0d empty, %0d full).",
                 beats_sent, beats_checked, joined_hits, empty_hits, full_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #(40_000_000);
        $display("Timeout: run did not finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/ufr_pkg.sv
rtl/core/ufr_ram.sv
rtl/core/union_find_with_rollback_unit.sv
tb/testbench.sv
